// File: hw/rtl/wheel_speed_pi_controller_assert.svh
// Assertion macros for the wheel speed PI controller.
`ifndef WHEEL_SPEED_PI_CONTROLLER_ASSERT_SVH
`define WHEEL_SPEED_PI_CONTROLLER_ASSERT_SVH

`ifndef ASSERT_OFF
`define WSPI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wspi assertion failed");
`define WSPI_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wspi assertion failed");
`else
`define WSPI_ASSERT_IMP(lbl, ante, cons)
`define WSPI_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// File: hw/rtl/wspi_pkg.sv
// Types, constants and control program of the wheel speed PI controller.
package wspi_pkg;

  localparam int TGT_W       = 16;
  localparam int CNT_W       = 16;
  localparam int DRV_W       = 8;
  localparam int GAIN_W      = 24;
  localparam int ALPHA_W     = 16;
  localparam int ILIM_W      = 16;
  localparam int DLIM_W      = 7;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;
  localparam int FRAC_W      = 16;
  localparam int SCALE_SHIFT = GAIN_W - FRAC_W;
  localparam int STATE_W     = 40;
  localparam int MEAN_W      = CNT_W + 1;
  localparam int ERR_W       = 34;
  localparam int MA_W        = GAIN_W + 1;
  localparam int MB_W        = STATE_W;
  localparam int PROD_W      = MA_W + MB_W;
  localparam int DRV_SHIFT   = GAIN_W + FRAC_W;
  localparam int PC_W        = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ALPHA = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_SCALE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEG_LIMIT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_LIMIT  = 3'd5;

  localparam logic [GAIN_W-1:0]  RST_PROP_GAIN    = 24'd2097152;
  localparam logic [GAIN_W-1:0]  RST_INTEG_GAIN   = 24'd12583;
  localparam logic [ALPHA_W-1:0] RST_FILTER_ALPHA = 16'd19661;
  localparam logic [GAIN_W-1:0]  RST_SPEED_SCALE  = 24'd365794;
  localparam logic [ILIM_W-1:0]  RST_INTEG_LIMIT  = 16'd150;
  localparam logic [DLIM_W-1:0]  RST_DRIVE_LIMIT  = 7'd100;

  localparam logic [PC_W-1:0] PC_IDLE = 4'd0;
  localparam logic [PC_W-1:0] PC_LAST = 4'd8;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_TGT_SCALE,
    MUL_KEEP_FILT,
    MUL_ALPHA_ERR,
    MUL_PROP_FILT,
    MUL_IGAIN_INTEG
  } mul_sel_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_ERR,
    OP_LOAD,
    OP_ADD,
    OP_ADD_FILT,
    OP_INTEG
  } dp_op_t;

  typedef enum logic [1:0] {
    JMP_SEQ,
    JMP_WAIT_IN,
    JMP_WAIT_OUT
  } jmp_t;

  typedef struct packed {
    mul_sel_t mul_sel;
    dp_op_t   op;
    jmp_t     jmp;
  } ucode_t;

  typedef struct packed {
    logic     capture;
    mul_sel_t mul_sel;
    dp_op_t   op;
  } dp_ctrl_t;

  // Each step that uses a product consumes the one registered by the step before it.
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    w = '{mul_sel: MUL_NONE, op: OP_NOP, jmp: JMP_SEQ};
    unique case (pc)
      4'd0: w = '{mul_sel: MUL_NONE,        op: OP_NOP,      jmp: JMP_WAIT_IN};
      4'd1: w = '{mul_sel: MUL_TGT_SCALE,   op: OP_NOP,      jmp: JMP_SEQ};
      4'd2: w = '{mul_sel: MUL_KEEP_FILT,   op: OP_ERR,      jmp: JMP_SEQ};
      4'd3: w = '{mul_sel: MUL_ALPHA_ERR,   op: OP_LOAD,     jmp: JMP_SEQ};
      4'd4: w = '{mul_sel: MUL_NONE,        op: OP_ADD_FILT, jmp: JMP_SEQ};
      4'd5: w = '{mul_sel: MUL_PROP_FILT,   op: OP_INTEG,    jmp: JMP_SEQ};
      4'd6: w = '{mul_sel: MUL_IGAIN_INTEG, op: OP_LOAD,     jmp: JMP_SEQ};
      4'd7: w = '{mul_sel: MUL_NONE,        op: OP_ADD,      jmp: JMP_SEQ};
      4'd8: w = '{mul_sel: MUL_NONE,        op: OP_NOP,      jmp: JMP_WAIT_OUT};
      default: w = '{mul_sel: MUL_NONE, op: OP_NOP, jmp: JMP_SEQ};
    endcase
    return w;
  endfunction

endpackage

// File: hw/rtl/wspi_datapath.sv
// Datapath of the wheel speed PI controller: shared multiplier, accumulator and state.
module wspi_datapath
  import wspi_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  dp_ctrl_t                  ctrl,
  input  logic signed [TGT_W-1:0]   in_target_speed,
  input  logic signed [CNT_W-1:0]   in_left_count,
  input  logic signed [CNT_W-1:0]   in_right_count,
  input  logic [GAIN_W-1:0]         prop_gain,
  input  logic [GAIN_W-1:0]         integ_gain,
  input  logic [ALPHA_W-1:0]        filter_alpha,
  input  logic [GAIN_W-1:0]         speed_scale,
  input  logic [ILIM_W-1:0]         integ_limit,
  input  logic [DLIM_W-1:0]         drive_limit,
  output logic signed [DRV_W-1:0]   drive_value
);

  logic signed [TGT_W-1:0]   tgt_r;
  logic signed [MEAN_W-1:0]  mean_r;
  logic signed [ERR_W-1:0]   err_r;
  logic signed [STATE_W-1:0] filt_r;
  logic signed [STATE_W-1:0] integ_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [PROD_W-1:0]  acc_r;

  logic signed [MEAN_W:0]    cnt_sum;
  logic signed [MEAN_W:0]    cnt_adj;
  logic [ALPHA_W:0]          keep_w;
  logic signed [MA_W-1:0]    mul_a;
  logic signed [MB_W-1:0]    mul_b;
  logic signed [PROD_W-1:0]  acc_sum;
  logic signed [STATE_W:0]   integ_sum;
  logic signed [STATE_W:0]   integ_lim;
  logic signed [PROD_W-1:0]  drive_lim;
  logic signed [PROD_W-1:0]  acc_adj;

  // The mean of the negated counts is truncated toward zero.
  always_comb begin
    cnt_sum = (MEAN_W+1)'(0) - (MEAN_W+1)'(in_left_count) - (MEAN_W+1)'(in_right_count);
    cnt_adj = cnt_sum + $signed({{MEAN_W{1'b0}}, cnt_sum[MEAN_W]});
  end

  assign keep_w = (ALPHA_W+1)'(1 << ALPHA_W) - {1'b0, filter_alpha};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctrl.mul_sel)
      MUL_TGT_SCALE: begin
        mul_a = $signed({1'b0, speed_scale});
        mul_b = MB_W'(tgt_r);
      end
      MUL_KEEP_FILT: begin
        mul_a = $signed({{(MA_W-ALPHA_W-1){1'b0}}, keep_w});
        mul_b = filt_r;
      end
      MUL_ALPHA_ERR: begin
        mul_a = $signed({{(MA_W-ALPHA_W){1'b0}}, filter_alpha});
        mul_b = MB_W'(err_r);
      end
      MUL_PROP_FILT: begin
        mul_a = $signed({1'b0, prop_gain});
        mul_b = filt_r;
      end
      MUL_IGAIN_INTEG: begin
        mul_a = $signed({1'b0, integ_gain});
        mul_b = integ_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign acc_sum   = acc_r + prod_r;
  assign integ_sum = (STATE_W+1)'(integ_r) + (STATE_W+1)'(filt_r);
  assign integ_lim = $signed({{(STATE_W+1-ILIM_W-FRAC_W){1'b0}}, integ_limit,
                              {FRAC_W{1'b0}}});

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
    if (ctrl.capture) begin
      tgt_r  <= in_target_speed;
      mean_r <= cnt_adj[MEAN_W:1];
    end
    case (ctrl.op)
      OP_ERR:  err_r <= $signed({mean_r[MEAN_W-1], mean_r, {FRAC_W{1'b0}}})
                        - $signed(prod_r[ERR_W+SCALE_SHIFT-1:SCALE_SHIFT]);
      OP_LOAD: acc_r <= prod_r;
      OP_ADD:  acc_r <= acc_sum;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filt_r  <= '0;
      integ_r <= '0;
    end else begin
      if (ctrl.op == OP_ADD_FILT) begin
        filt_r <= acc_sum[STATE_W+FRAC_W-1:FRAC_W];
      end
      if (ctrl.op == OP_INTEG) begin
        if (integ_sum > integ_lim) begin
          integ_r <= STATE_W'(integ_lim);
        end else if (integ_sum < -integ_lim) begin
          integ_r <= STATE_W'(-integ_lim);
        end else begin
          integ_r <= STATE_W'(integ_sum);
        end
      end
    end
  end

  // The quotient by 2^40 is truncated toward zero after the clamp.
  assign drive_lim = $signed({{(PROD_W-DLIM_W-DRV_SHIFT){1'b0}}, drive_limit,
                              {DRV_SHIFT{1'b0}}});
  assign acc_adj   = acc_r + $signed({{(PROD_W-DRV_SHIFT){1'b0}},
                                      {DRV_SHIFT{acc_r[PROD_W-1]}}});

  always_comb begin
    if (acc_r > drive_lim) begin
      drive_value = $signed({1'b0, drive_limit});
    end else if (acc_r < -drive_lim) begin
      drive_value = -$signed({1'b0, drive_limit});
    end else begin
      drive_value = acc_adj[DRV_SHIFT+DRV_W-1:DRV_SHIFT];
    end
  end

endmodule

// File: hw/rtl/wheel_speed_pi_controller.sv
// Top level of the wheel speed PI controller: registers, microcode sequencer and output stage.
// One transaction in gives one drive value out. A nine-step microprogram drives one shared
// 25 x 40 bit multiplier; an item is accepted only at its first step and its result loads the
// output register at the last step, so a new item waits until the last one is through. While a
// finished result still waits at the output, the program holds at its last step until the
// output register frees. The user must write the configuration registers through the cfg
// port only while no transaction is in flight; the block itself does not enforce it.
`include "wheel_speed_pi_controller_assert.svh"

module wheel_speed_pi_controller
  import wspi_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [TGT_W-1:0]      in_target_speed,
  input  logic signed [CNT_W-1:0]      in_left_count,
  input  logic signed [CNT_W-1:0]      in_right_count,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [DRV_W-1:0]      out_drive_value,
  input  logic                         cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data
);

  logic [GAIN_W-1:0]       prop_gain_r;
  logic [GAIN_W-1:0]       integ_gain_r;
  logic [ALPHA_W-1:0]      filter_alpha_r;
  logic [GAIN_W-1:0]       speed_scale_r;
  logic [ILIM_W-1:0]       integ_limit_r;
  logic [DLIM_W-1:0]       drive_limit_r;

  logic [PC_W-1:0]         pc_r;
  logic [PC_W-1:0]         pc_nxt;
  logic                    out_valid_r;
  logic                    out_valid_nxt;
  logic signed [DRV_W-1:0] out_drive_value_r;
  logic signed [DRV_W-1:0] out_drive_value_nxt;

  ucode_t                  cw;
  dp_ctrl_t                dp_ctrl;
  logic                    in_fire;
  logic                    out_free;
  logic                    out_load;
  logic signed [DRV_W-1:0] drive_value;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r    <= RST_PROP_GAIN;
      integ_gain_r   <= RST_INTEG_GAIN;
      filter_alpha_r <= RST_FILTER_ALPHA;
      speed_scale_r  <= RST_SPEED_SCALE;
      integ_limit_r  <= RST_INTEG_LIMIT;
      drive_limit_r  <= RST_DRIVE_LIMIT;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_PROP_GAIN:    prop_gain_r    <= cfg_data[GAIN_W-1:0];
        CFG_INTEG_GAIN:   integ_gain_r   <= cfg_data[GAIN_W-1:0];
        CFG_FILTER_ALPHA: filter_alpha_r <= cfg_data[ALPHA_W-1:0];
        CFG_SPEED_SCALE:  speed_scale_r  <= cfg_data[GAIN_W-1:0];
        CFG_INTEG_LIMIT:  integ_limit_r  <= cfg_data[ILIM_W-1:0];
        CFG_DRIVE_LIMIT:  drive_limit_r  <= cfg_data[DLIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign cw       = ucode_rom(pc_r);
  assign in_stall = (pc_r != PC_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign out_load = (cw.jmp == JMP_WAIT_OUT) && out_free;

  always_comb begin
    unique case (cw.jmp)
      JMP_SEQ:      pc_nxt = pc_r + PC_W'(1);
      JMP_WAIT_IN:  pc_nxt = in_fire ? pc_r + PC_W'(1) : pc_r;
      JMP_WAIT_OUT: pc_nxt = out_free ? PC_IDLE : pc_r;
      default:      pc_nxt = PC_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt       = out_valid_r && out_stall;
    out_drive_value_nxt = out_drive_value_r;
    if (out_load) begin
      out_valid_nxt       = 1'b1;
      out_drive_value_nxt = drive_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= PC_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_drive_value_r <= out_drive_value_nxt;
  end

  assign dp_ctrl = '{capture: in_fire, mul_sel: cw.mul_sel, op: cw.op};

  wspi_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctrl            (dp_ctrl),
    .in_target_speed (in_target_speed),
    .in_left_count   (in_left_count),
    .in_right_count  (in_right_count),
    .prop_gain       (prop_gain_r),
    .integ_gain      (integ_gain_r),
    .filter_alpha    (filter_alpha_r),
    .speed_scale     (speed_scale_r),
    .integ_limit     (integ_limit_r),
    .drive_limit     (drive_limit_r),
    .drive_value     (drive_value)
  );

  assign out_valid       = out_valid_r;
  assign out_drive_value = out_drive_value_r;

  `WSPI_ASSERT_NXT(a_accept_starts_program, in_fire, pc_r == PC_IDLE + PC_W'(1))
  `WSPI_ASSERT_NXT(a_last_step_loads_output, (pc_r == PC_LAST) && out_free, out_valid_r)
  `WSPI_ASSERT_IMP(a_drive_within_limit, out_valid_r,
                   ($signed(out_drive_value_r) <= $signed({1'b0, drive_limit_r})) &&
                   ($signed(out_drive_value_r) >= -$signed({1'b0, drive_limit_r})))

endmodule
